>>> rtl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// shared widths, types and constants of the ray versus box slab test
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int FRAC_BITS = 16;                 // coordinate fraction bits
  localparam int CW        = 32;                 // coordinate width
  localparam int DW        = CW + 1;             // corner minus origin width
  localparam int NW        = DW + FRAC_BITS;     // scaled numerator width
  localparam int HW        = NW - CW;            // numerator bits above quotient
  localparam int DIV_LAT   = CW + 3;             // abs, setup, steps, finish
  localparam int LAT       = DIV_LAT + 4;        // input reg, divider, fold x3

  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

  // one restoring divider stage: partial remainder, shifting numerator and
  // quotient word, divisor and result sign / overflow
  typedef struct packed {
    logic [CW-1:0] r;
    logic [CW-1:0] nq;
    logic [CW-1:0] d;
    logic          neg;
    logic          ovf;
  } div_pipe_t;

  // zero direction handling of one axis
  typedef struct packed {
    logic zero;
    logic in_slab;
    logic below;
  } axis_flag_t;

endpackage

>>> rtl/rbs_div_step.sv
// ----------------------------------------------------------------------------
// rbs_div_step
// one registered restoring division step, one quotient bit
// ----------------------------------------------------------------------------
module rbs_div_step
  import rbs_pkg::*;
(
  input  logic      clk,
  input  div_pipe_t d_in,
  output div_pipe_t d_out
);

  logic [CW:0]   trial;
  logic          ge;
  logic [CW:0]   diff;
  div_pipe_t     nxt;

  always_comb begin
    trial = {d_in.r, d_in.nq[CW-1]};
    diff  = trial - {1'b0, d_in.d};
    ge    = trial >= {1'b0, d_in.d};
    nxt   = d_in;
    nxt.r  = ge ? diff[CW-1:0] : trial[CW-1:0];
    nxt.nq = {d_in.nq[CW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    d_out <= nxt;
  end

endmodule

>>> rtl/rbs_slab_div.sv
// ----------------------------------------------------------------------------
// rbs_slab_div
// pipelined signed quotient (diff << FRAC_BITS) / dir, truncated, saturated
// ----------------------------------------------------------------------------
module rbs_slab_div
  import rbs_pkg::*;
(
  input  logic                 clk,
  input  logic signed [DW-1:0] diff,
  input  logic signed [CW-1:0] dir,
  output logic signed [CW-1:0] t_slab
);

  logic [NW-1:0] n_mag;
  logic [CW-1:0] d_mag;
  logic          neg1;
  logic [DW-1:0] diff_abs;
  logic [CW-1:0] dir_abs;
  div_pipe_t     stg0;
  div_pipe_t     stg [0:CW];
  logic [CW-1:0] q;
  logic          big;

  assign diff_abs = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign dir_abs  = dir[CW-1] ? CW'(-dir) : CW'(dir);

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    n_mag <= {diff_abs, {FRAC_BITS{1'b0}}};
    d_mag <= dir_abs;
    neg1  <= diff[DW-1] ^ dir[CW-1];
  end

  // overflow check and remainder setup
  always_ff @(posedge clk) begin
    stg0.r   <= {{(CW-HW){1'b0}}, n_mag[NW-1:CW]};
    stg0.nq  <= n_mag[CW-1:0];
    stg0.d   <= d_mag;
    stg0.neg <= neg1;
    stg0.ovf <= {{(CW-HW){1'b0}}, n_mag[NW-1:CW]} >= d_mag;
  end

  assign stg[0] = stg0;

  for (genvar i = 0; i < CW; i++) begin : g_step
    rbs_div_step u_step (
      .clk   (clk),
      .d_in  (stg[i]),
      .d_out (stg[i+1])
    );
  end

  assign q   = stg[CW].nq;
  assign big = stg[CW].ovf;

  // sign and saturation
  always_ff @(posedge clk) begin
    if (stg[CW].neg) begin
      if (big || (q[CW-1] && (q[CW-2:0] != '0))) begin
        t_slab <= T_MIN;
      end else begin
        t_slab <= CW'(-q);
      end
    end else begin
      if (big || q[CW-1]) begin
        t_slab <= T_MAX;
      end else begin
        t_slab <= q;
      end
    end
  end

endmodule

>>> rtl/rbs_fold.sv
// ----------------------------------------------------------------------------
// rbs_fold
// orders slab distances per axis, folds axes, forms the hit flag
// ----------------------------------------------------------------------------
module rbs_fold
  import rbs_pkg::*;
(
  input  logic                 clk,
  input  logic signed [CW-1:0] dist_lo [3],
  input  logic signed [CW-1:0] dist_hi [3],
  input  axis_flag_t           flags   [3],
  output logic                 hit,
  output logic signed [CW-1:0] t_entry,
  output logic signed [CW-1:0] t_exit
);

  logic signed [CW-1:0] near_d [3];
  logic signed [CW-1:0] far_d  [3];
  logic [2:0]           miss_d;
  logic signed [CW-1:0] n01, f01;
  logic signed [CW-1:0] entry, exit_t;
  logic                 miss;

  // per axis near / far
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (flags[a].zero) begin
        if (flags[a].in_slab) begin
          near_d[a] <= T_MIN;
          far_d[a]  <= T_MAX;
          miss_d[a] <= 1'b0;
        end else if (flags[a].below) begin
          near_d[a] <= T_MAX;
          far_d[a]  <= T_MAX;
          miss_d[a] <= 1'b1;
        end else begin
          near_d[a] <= T_MIN;
          far_d[a]  <= T_MIN;
          miss_d[a] <= 1'b1;
        end
      end else begin
        near_d[a] <= (dist_lo[a] < dist_hi[a]) ? dist_lo[a] : dist_hi[a];
        far_d[a]  <= (dist_lo[a] < dist_hi[a]) ? dist_hi[a] : dist_lo[a];
        miss_d[a] <= 1'b0;
      end
    end
  end

  assign n01 = (near_d[0] > near_d[1]) ? near_d[0] : near_d[1];
  assign f01 = (far_d[0] < far_d[1]) ? far_d[0] : far_d[1];

  // axis fold
  always_ff @(posedge clk) begin
    entry  <= (near_d[2] > n01) ? near_d[2] : n01;
    exit_t <= (far_d[2] < f01) ? far_d[2] : f01;
    miss   <= |miss_d;
  end

  // hit test and result register
  always_ff @(posedge clk) begin
    hit     <= !miss && (exit_t >= entry) && !exit_t[CW-1];
    t_entry <= entry;
    t_exit  <= exit_t;
  end

endmodule

>>> rtl/ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test
// ray versus axis-aligned box slab test, Q16.16, fully pipelined
// ----------------------------------------------------------------------------
// done marks the result once the start transfer has passed the input register,
// the slab dividers and the fold registers
// throughput: one item per cycle; busy is always low, the pipeline never stalls
// the 32 one-bit steps of the six slab dividers set the depth
// reset clears the valid line only; results of items in flight are dropped
// payload registers carry no reset
module ray_box_slab_test
  import rbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] origin_x,
  input  logic signed [CW-1:0] origin_y,
  input  logic signed [CW-1:0] origin_z,
  input  logic signed [CW-1:0] dir_x,
  input  logic signed [CW-1:0] dir_y,
  input  logic signed [CW-1:0] dir_z,
  input  logic signed [CW-1:0] box_lo_x,
  input  logic signed [CW-1:0] box_lo_y,
  input  logic signed [CW-1:0] box_lo_z,
  input  logic signed [CW-1:0] box_hi_x,
  input  logic signed [CW-1:0] box_hi_y,
  input  logic signed [CW-1:0] box_hi_z,
  output logic                 done,
  output logic                 hit,
  output logic signed [CW-1:0] t_entry,
  output logic signed [CW-1:0] t_exit
);

  logic signed [CW-1:0] org_a [3];
  logic signed [CW-1:0] dir_a [3];
  logic signed [CW-1:0] lo_a  [3];
  logic signed [CW-1:0] hi_a  [3];

  // input stage registers
  logic signed [DW-1:0] diff_lo [3];
  logic signed [DW-1:0] diff_hi [3];
  logic signed [CW-1:0] dir_r   [3];
  axis_flag_t           flag_r  [3];

  // flag delay line alongside the dividers
  axis_flag_t           flag_d  [DIV_LAT][3];

  logic signed [CW-1:0] dist_lo [3];
  logic signed [CW-1:0] dist_hi [3];

  logic [LAT-1:0]       vld;
  logic                 fire;

  assign org_a = '{origin_x, origin_y, origin_z};
  assign dir_a = '{dir_x, dir_y, dir_z};
  assign lo_a  = '{box_lo_x, box_lo_y, box_lo_z};
  assign hi_a  = '{box_hi_x, box_hi_y, box_hi_z};

  // a new item every cycle, so never busy
  assign busy = 1'b0;
  assign fire = start && !busy;

  // valid bits travel beside the data, one per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], fire};
    end
  end

  assign done = vld[LAT-1];

  // corner minus origin at full width, zero direction classification
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      diff_lo[a]        <= DW'(lo_a[a]) - DW'(org_a[a]);
      diff_hi[a]        <= DW'(hi_a[a]) - DW'(org_a[a]);
      dir_r[a]          <= dir_a[a];
      flag_r[a].zero    <= (dir_a[a] == '0);
      flag_r[a].in_slab <= (lo_a[a] <= org_a[a]) && (org_a[a] <= hi_a[a]);
      flag_r[a].below   <= (org_a[a] < lo_a[a]);
    end
  end

  // keep flags aligned with the divider outputs
  always_ff @(posedge clk) begin
    flag_d[0] <= flag_r;
    for (int s = 1; s < DIV_LAT; s++) begin
      flag_d[s] <= flag_d[s-1];
    end
  end

  // six slab dividers, two per axis
  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_slab_div u_div_lo (
      .clk    (clk),
      .diff   (diff_lo[a]),
      .dir    (dir_r[a]),
      .t_slab (dist_lo[a])
    );
    rbs_slab_div u_div_hi (
      .clk    (clk),
      .diff   (diff_hi[a]),
      .dir    (dir_r[a]),
      .t_slab (dist_hi[a])
    );
  end

  // ordering, folding, hit flag and result registers
  rbs_fold u_fold (
    .clk     (clk),
    .dist_lo (dist_lo),
    .dist_hi (dist_hi),
    .flags   (flag_d[DIV_LAT-1]),
    .hit     (hit),
    .t_entry (t_entry),
    .t_exit  (t_exit)
  );

  // each transfer is followed by its done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    fire |-> ##(LAT) done) else $error("result missing after pipeline latency");

  // a hit always has a non-negative exit no earlier than the entry
  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (t_exit >= t_entry) && !t_exit[CW-1])
    else $error("hit with inconsistent distances");

  // no result without a matching earlier transfer
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(fire, LAT)) else $error("result without a transfer");

endmodule

>>> test/ray_box_slab_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_tb
// self-checking bench for the ray versus box slab test: a directed set of
// rays and boxes, then random ones, each result checked against a predicted
// entry distance, exit distance and hit flag
// ----------------------------------------------------------------------------
module ray_box_slab_test_tb;
  import rbs_pkg::*;

  typedef logic signed [CW-1:0] coord_t;

  // expected outcome of one ray / box test
  typedef struct {
    logic   hit;
    coord_t t_entry;
    coord_t t_exit;
  } slab_result_t;

  // saturate a wide signed value to the 32 bit distance range
  function automatic coord_t sat_dist(longint v);
    if (v > longint'(T_MAX)) return T_MAX;
    if (v < longint'(T_MIN)) return T_MIN;
    return coord_t'(v);
  endfunction

  // predicted slab test; every axis narrows the entry / exit window
  function automatic slab_result_t slab_predict(coord_t o[3], coord_t d[3],
                                                coord_t lo[3], coord_t hi[3]);
    slab_result_t res;
    longint entry, exit_t, near_t, far_t, ta, tb, dl;
    logic miss;
    entry = longint'(T_MIN);
    exit_t = longint'(T_MAX);
    miss = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      dl = longint'(d[ax]);
      if (dl == 0) begin
        if (lo[ax] <= o[ax] && o[ax] <= hi[ax]) begin
          near_t = longint'(T_MIN); far_t = longint'(T_MAX);
        end else if (o[ax] < lo[ax]) begin
          near_t = longint'(T_MAX); far_t = longint'(T_MAX); miss = 1'b1;
        end else begin
          near_t = longint'(T_MIN); far_t = longint'(T_MIN); miss = 1'b1;
        end
      end else begin
        // sv division truncates toward zero, as required
        ta = longint'(sat_dist(((longint'(lo[ax]) - longint'(o[ax])) <<< FRAC_BITS) / dl));
        tb = longint'(sat_dist(((longint'(hi[ax]) - longint'(o[ax])) <<< FRAC_BITS) / dl));
        near_t = (ta < tb) ? ta : tb;
        far_t = (ta < tb) ? tb : ta;
      end
      if (near_t > entry) entry = near_t;
      if (far_t < exit_t) exit_t = far_t;
    end
    res.hit = !miss && exit_t >= entry && exit_t >= 0;
    res.t_entry = coord_t'(entry);
    res.t_exit = coord_t'(exit_t);
    return res;
  endfunction

  // holds predicted outcomes in transfer order and checks arriving results
  class slab_scoreboard;
    slab_result_t pending[$];
    int errors = 0;

    function void note_item(slab_result_t r);
      pending.push_back(r);
    endfunction

    function void check_result(logic h, coord_t te, coord_t tx);
      slab_result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (h !== e.hit) begin
        $error("hit: expected %0d actual %0d", e.hit, h); errors++;
      end
      if (te !== e.t_entry) begin
        $error("t_entry: expected %0d actual %0d", e.t_entry, te); errors++;
      end
      if (tx !== e.t_exit) begin
        $error("t_exit: expected %0d actual %0d", e.t_exit, tx); errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, hit;
  coord_t origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
  coord_t box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z;
  coord_t t_entry, t_exit;

  slab_scoreboard board;
  int idle_pct;

  ray_box_slab_test u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .box_lo_x(box_lo_x), .box_lo_y(box_lo_y), .box_lo_z(box_lo_z),
    .box_hi_x(box_hi_x), .box_hi_y(box_hi_y), .box_hi_z(box_hi_z),
    .done(done), .hit(hit), .t_entry(t_entry), .t_exit(t_exit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous limit on the run; a run that reaches it is reported as a fail
  initial begin
    #5_000_000;
    $display("ray_box_slab_test regression: fail");
    $finish;
  end

  // results are sampled at the rising edge that ends the strobe cycle
  always @(posedge clk) begin
    if (!rst && done) board.check_result(hit, t_entry, t_exit);
  end

  // drive one item and hold it until its transfer, then optionally idle
  task automatic send_item(coord_t o[3], coord_t d[3], coord_t lo[3], coord_t hi[3]);
    origin_x <= o[0]; origin_y <= o[1]; origin_z <= o[2];
    dir_x <= d[0]; dir_y <= d[1]; dir_z <= d[2];
    box_lo_x <= lo[0]; box_lo_y <= lo[1]; box_lo_z <= lo[2];
    box_hi_x <= hi[0]; box_hi_y <= hi[1]; box_hi_z <= hi[2];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_item(slab_predict(o, d, lo, hi));
    @(negedge clk);
    // start stays high into the next item unless a gap is taken here
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // random coordinate, biased toward small values and the extremes
  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return T_MAX;
      1:       return T_MIN;
      2:       return 0;
      3, 4:    return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
    endcase
  endfunction

  // random direction: often zero or small so the divisions span their range
  function automatic coord_t rand_dir();
    case ($urandom_range(9))
      0, 1:    return 0;
      2:       return coord_t'(int'($urandom_range(0, 8)) - 4);
      3:       return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4);
    endcase
  endfunction

  // random ray and box; mostly well ordered boxes, some inverted
  task automatic send_random();
    coord_t o[3], d[3], lo[3], hi[3], t;
    for (int ax = 0; ax < 3; ax++) begin
      o[ax] = rand_coord(); d[ax] = rand_dir();
      lo[ax] = rand_coord(); hi[ax] = rand_coord();
      if ($urandom_range(9) != 0 && lo[ax] > hi[ax]) begin
        t = lo[ax]; lo[ax] = hi[ax]; hi[ax] = t;
      end
      // zero direction with origin on a slab face
      if (d[ax] == 0 && $urandom_range(3) == 0) o[ax] = $urandom_range(1) ? lo[ax] : hi[ax];
    end
    send_item(o, d, lo, hi);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    coord_t o[3], d[3], lo[3], hi[3];
    board = new();
    rst = 1'b1; start = 1'b0;
    {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} = '0;
    {box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_pct = 14;

    // directed: plain hit through a unit box
    o = '{-2 <<< 16, 32'sh8000, 32'sh8000}; d = '{1 <<< 16, 0, 0};
    lo = '{0, 0, 0}; hi = '{1 <<< 16, 1 <<< 16, 1 <<< 16};
    send_item(o, d, lo, hi);
    // negative direction, box behind the ray
    d = '{-(1 <<< 16), 0, 0}; send_item(o, d, lo, hi);
    // zero direction below, above and on both faces of the slab
    o = '{32'sh8000, -5, 32'sh8000}; d = '{1 <<< 16, 0, 0}; send_item(o, d, lo, hi);
    o[1] = 2 <<< 16; send_item(o, d, lo, hi);
    o[1] = 0; send_item(o, d, lo, hi);
    o[1] = 1 <<< 16; send_item(o, d, lo, hi);
    // all directions zero, origin inside
    o = '{1, 1, 1}; d = '{0, 0, 0}; send_item(o, d, lo, hi);
    // inverted box
    lo = '{1 <<< 16, 1 <<< 16, 1 <<< 16}; hi = '{0, 0, 0};
    o = '{-(3 <<< 16), 32'sh8000, 32'sh8000}; d = '{1 <<< 16, 0, 0};
    send_item(o, d, lo, hi);
    // extremes: saturation both ways with tiny directions, then extreme directions and coordinates
    o = '{T_MIN, T_MAX, T_MIN}; d = '{1, -1, 32'sd1};
    lo = '{T_MAX, T_MIN, T_MIN}; hi = '{T_MAX, T_MAX, T_MAX};
    send_item(o, d, lo, hi);
    d = '{T_MIN, T_MAX, T_MIN}; send_item(o, d, lo, hi);
    o = '{T_MAX, T_MIN, 0}; d = '{-1, T_MIN, T_MAX}; lo = '{T_MIN, T_MIN, T_MIN};
    hi = '{T_MIN, T_MAX, 0}; send_item(o, d, lo, hi);
    o = '{-1, -1, -1}; d = '{-1, -1, -1}; lo = '{-1, -1, -1}; hi = '{-1, -1, -1};
    send_item(o, d, lo, hi);

    // sender pauses until every expected result has arrived
    wait_drained();
    @(negedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 14 : (ph == 1) ? 85 : 0;
      for (int n = 0; n < 550; n++) send_random();
    end

    wait_drained();
    repeat (LAT + 10) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ray_box_slab_test regression: pass");
    end else begin
      $display("ray_box_slab_test regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rbs_pkg.sv
rtl/rbs_div_step.sv
rtl/rbs_slab_div.sv
rtl/rbs_fold.sv
rtl/ray_box_slab_test.sv
test/ray_box_slab_test_tb.sv
